// File: hw/rtl/dhd_pkg.sv
// shared types and constants for the doubling and halving divider
package dhd_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic zero_div;
        logic skip_double;
    } class_t;

    localparam int CLASS_W = $bits(class_t);

endpackage

// File: hw/rtl/doubling_halving_divider.sv
// top level of the doubling and halving divider
// path: front register, then the back stage loads the divider, runs the
// doubling and halving steps and finishes into the output register; the back
// stage takes a new item only once the last is done, as the shift and
// subtract datapath is shared; a zero divisor skips doubling and halving
// reset: asynchronous active low, clears the queue, the sequencer and valids
module doubling_halving_divider #(
    parameter int DATA_WIDTH = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [DATA_WIDTH-1:0] dividend_in,
    input  logic [DATA_WIDTH-1:0] divisor_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic                  div_by_zero
);

    localparam int QW = 2 * DATA_WIDTH + dhd_pkg::CLASS_W;

    logic                  push;
    logic                  queue_full;
    logic                  queue_not_empty;
    logic                  pop;
    logic [DATA_WIDTH-1:0] f_dividend;
    logic [DATA_WIDTH-1:0] f_divisor;
    dhd_pkg::class_t       f_class;
    logic [QW-1:0]         q_in;
    logic [QW-1:0]         q_out;
    logic [DATA_WIDTH-1:0] b_dividend;
    logic [DATA_WIDTH-1:0] b_divisor;
    dhd_pkg::class_t       b_class;

    dhd_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .dividend_in (dividend_in),
        .divisor_in  (divisor_in),
        .push        (push),
        .queue_full  (queue_full),
        .dividend    (f_dividend),
        .divisor     (f_divisor),
        .item_class  (f_class)
    );

    assign q_in = {f_dividend, f_divisor, f_class};

    dhd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_data  (q_out)
    );

    assign b_dividend = q_out[QW-1 -: DATA_WIDTH];
    assign b_divisor  = q_out[dhd_pkg::CLASS_W +: DATA_WIDTH];
    assign b_class    = q_out[dhd_pkg::CLASS_W-1:0];

    dhd_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .not_empty   (queue_not_empty),
        .pop         (pop),
        .dividend    (b_dividend),
        .divisor     (b_divisor),
        .item_class  (b_class),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .quotient    (quotient),
        .div_by_zero (div_by_zero)
    );

endmodule

// File: hw/rtl/dhd_front.sv
// front stage: takes input items and classifies them before queueing
module dhd_front #(
    parameter int DATA_WIDTH = 31
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [DATA_WIDTH-1:0]               dividend_in,
    input  logic [DATA_WIDTH-1:0]               divisor_in,
    output logic                                push,
    input  logic                                queue_full,
    output logic [DATA_WIDTH-1:0]               dividend,
    output logic [DATA_WIDTH-1:0]               divisor,
    output dhd_pkg::class_t                     item_class
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] dividend_reg;
    logic [DATA_WIDTH-1:0] divisor_reg;
    dhd_pkg::class_t       class_reg;
    dhd_pkg::class_t       class_next;
    logic                  take;

    assign push     = valid_reg && !queue_full;
    assign in_stall = valid_reg && queue_full;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        class_next.zero_div    = (divisor_in == '0);
        class_next.skip_double = (divisor_in >= dividend_in);
        valid_next             = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dividend_reg <= dividend_in;
            divisor_reg  <= divisor_in;
            class_reg    <= class_next;
        end
    end

    assign dividend   = dividend_reg;
    assign divisor    = divisor_reg;
    assign item_class = class_reg;

endmodule

// File: hw/rtl/dhd_queue.sv
// short item queue between front and back
module dhd_queue #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0]           mem_reg [dhd_pkg::QUEUE_DEPTH];
    logic [dhd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [dhd_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [dhd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [dhd_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [dhd_pkg::QCNT_W-1:0] count_reg;
    logic [dhd_pkg::QCNT_W-1:0] count_next;
    logic                       do_push;
    logic                       do_pop;

    assign full      = (count_reg == dhd_pkg::QCNT_W'(dhd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/dhd_back.sv
// back stage: iterative doubling and halving division with output register
module dhd_back #(
    parameter int DATA_WIDTH = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  not_empty,
    output logic                  pop,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    input  dhd_pkg::class_t       item_class,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic                  div_by_zero
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DOUBLE = 2'd1;
    localparam logic [1:0] ST_HALVE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH:0]   sd_reg;
    logic [DATA_WIDTH:0]   sd_next;
    logic [DATA_WIDTH:0]   wt_reg;
    logic [DATA_WIDTH:0]   wt_next;
    logic [DATA_WIDTH-1:0] q_reg;
    logic [DATA_WIDTH-1:0] q_next;
    logic                  dbz_reg;
    logic                  dbz_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DATA_WIDTH-1:0] out_q_reg;
    logic                  out_dbz_reg;
    logic                  out_free;
    logic                  load_out;
    logic                  fits;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == ST_IDLE) && not_empty;
    assign load_out = (state_reg == ST_FINISH) && out_free;
    assign fits     = (sd_reg <= {1'b0, rem_reg});

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        sd_next    = sd_reg;
        wt_next    = wt_reg;
        q_next     = q_reg;
        dbz_next   = dbz_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (not_empty)
                begin
                    rem_next = dividend;
                    sd_next  = {1'b0, divisor};
                    wt_next  = (DATA_WIDTH + 1)'(1);
                    q_next   = '0;
                    dbz_next = item_class.zero_div;
                    if (item_class.zero_div)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (item_class.skip_double)
                    begin
                        state_next = ST_HALVE;
                    end
                    else
                    begin
                        state_next = ST_DOUBLE;
                    end
                end
            end
            ST_DOUBLE:
            begin
                if (sd_reg < {1'b0, rem_reg})
                begin
                    sd_next = {sd_reg[DATA_WIDTH-1:0], 1'b0};
                    wt_next = {wt_reg[DATA_WIDTH-1:0], 1'b0};
                end
                else
                begin
                    state_next = ST_HALVE;
                end
            end
            ST_HALVE:
            begin
                if (wt_reg != '0)
                begin
                    if (fits)
                    begin
                        q_next   = q_reg + wt_reg[DATA_WIDTH-1:0];
                        rem_next = rem_reg - sd_reg[DATA_WIDTH-1:0];
                    end
                    sd_next = {1'b0, sd_reg[DATA_WIDTH:1]};
                    wt_next = {1'b0, wt_reg[DATA_WIDTH:1]};
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sd_reg  <= sd_next;
        wt_reg  <= wt_next;
        q_reg   <= q_next;
        dbz_reg <= dbz_next;
        if (load_out)
        begin
            out_q_reg   <= q_reg;
            out_dbz_reg <= dbz_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign quotient    = out_q_reg;
    assign div_by_zero = out_dbz_reg;

endmodule
